/* design/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int MAX_EXTENTS  = 64;
    localparam int EXT_AW       = $clog2(MAX_EXTENTS);
    localparam int CNT_W        = $clog2(MAX_EXTENTS + 1);
    localparam int GRANULE      = 8;
    localparam int HEADER_BYTES = 8;
    localparam int WORD_W       = 32;
    localparam int ALIGN_W      = 16;
    localparam int REM_W        = ALIGN_W + 1;
    localparam int DIV_CNT_W    = $clog2(WORD_W + 1);
    localparam int CFG_IDX_W    = 1;
    localparam int IN_DATA_W    = 80;
    localparam int OUT_DATA_W   = 136;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_MEMORY  = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_BASE   = 1'b0,
        CFG_HEAP_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_RD,
        S_A_WAIT,
        S_A_MOD,
        S_A_EVAL,
        S_F_RD,
        S_F_WAIT,
        S_F_DECIDE,
        S_INS,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL,
        S_DEL_RD,
        S_DEL_WR,
        S_STAT,
        S_ST_RD,
        S_ST_ACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] size;
    } ext_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ALIGN_W-1:0] rem;
    } mod_res_t;

    // Add two sizes and clamp at the largest word value.
    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/first_fit_heap_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator over an address-ordered table of free extents.
// ----------------------------------------------------------------------------
//  Channel  | Signals                            | Content
//  s_axis   | s_tvalid s_tready s_tdata s_tuser  | request item (action in tuser)
//  m_axis   | m_tvalid m_tready m_tdata          | result item with heap statistics
//  cfg      | cfg_valid cfg_ready cfg_index      | heap_base / heap_length writes
//           | cfg_data                           |
//
// The block works on one item at a time. An allocate reads each candidate
// extent and runs the bit-serial remainder unit for the alignment of its
// start. Deallocate scans the extents below the released address. Inserting
// or removing an extent shifts the table one entry at a time, and every item
// ends with a statistics sweep over all live extents through the table's
// read port. Reset leaves the table empty with no clearing pass. A result
// waits in the output register while m_tready is low; the next request is
// taken as soon as the previous result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // address[31:0], length[63:32], alignment[79:64]
    input  wire logic [ffha_pkg::IN_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  wire logic [1:0]                      s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // status[1:0], alloc_address[33:2], free_bytes[65:34],
    // largest_free[97:66], used_bytes[129:98], zero fill[135:130]
    output logic [ffha_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffha_pkg::WORD_W-1:0]     cfg_data
);
    import ffha_pkg::*;

    localparam logic [WORD_W-1:0] GMASK = ~(WORD_W'(GRANULE - 1));

    // Control and datapath registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   usable_reg, usable_next;
    logic [WORD_W-1:0]   base_cfg_reg, len_cfg_reg;
    logic [WORD_W-1:0]   len_in_reg, len_in_next;
    logic [ALIGN_W-1:0]  align_reg, align_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    ext_t                ins_reg, ins_next;
    ext_t                cur_reg, cur_next;
    ext_t                prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic [ALIGN_W-1:0]  off_reg, off_next;
    logic [WORD_W-1:0]   ra_reg, ra_next;
    logic [WORD_W-1:0]   rs_reg, rs_next;
    status_t             status_reg, status_next;
    logic [WORD_W-1:0]   granted_reg, granted_next;
    logic [WORD_W-1:0]   total_reg, total_next;
    logic [WORD_W-1:0]   largest_reg, largest_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Memory and remainder unit hookup.
    logic                mem_we, mem_re;
    logic [EXT_AW-1:0]   mem_waddr, mem_raddr;
    ext_t                mem_wdata, mem_rdata;
    logic                mod_start;
    mod_res_t            mod_res;
    logic [ALIGN_W-1:0]  align_eff;

    // Decoded request fields.
    action_t             in_act;
    logic [WORD_W-1:0]   in_addr, in_len;
    logic [ALIGN_W-1:0]  in_align;
    logic                accept;

    // Reinitialize terms.
    logic [2:0]          init_off;
    logic [WORD_W-1:0]   init_base, init_usable;

    // Deallocate rounding of the request.
    logic [WORD_W:0]     rs_wide;
    logic [WORD_W-1:0]   rs_in;

    // Allocate evaluation terms.
    logic [WORD_W:0]     need33, addr33;
    logic [WORD_W+1:0]   end34, sum34, tail34, tsz34;
    logic                a_fit, keep_lead, keep_tail, tbl_full, a_last;
    ext_t                lead_ext, tail_ext;

    // Deallocate evaluation terms.
    logic                f_below, cur_ok, merge_lo, merge_hi, merge_up, f_last;
    logic [WORD_W-1:0]   psize1, psize2, up_size;
    logic [WORD_W:0]     prev_end, prev_end2, rel_end;

    logic [CNT_W-1:0]    idx_inc, idx_dec;

    assign in_addr  = s_tdata[31:0];
    assign in_len   = s_tdata[63:32];
    assign in_align = s_tdata[79:64];
    assign in_act   = action_t'(s_tuser);

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign idx_inc = idx_reg + 1'b1;
    assign idx_dec = idx_reg - 1'b1;

    // The heap base is moved up to the next granule, the length shrinks by the
    // same amount and saturates at zero.
    assign init_off    = 3'(-base_cfg_reg[2:0]);
    assign init_base   = base_cfg_reg + WORD_W'(init_off);
    assign init_usable = (len_cfg_reg > WORD_W'(init_off)) ?
                         (len_cfg_reg - WORD_W'(init_off)) : '0;

    // A released length rounds up to the granule and clamps below 2^32.
    assign rs_wide = ({1'b0, in_len} + (WORD_W+1)'(GRANULE - 1)) & ~((WORD_W+1)'(GRANULE - 1));
    assign rs_in   = rs_wide[WORD_W] ? GMASK : rs_wide[WORD_W-1:0];

    assign align_eff = (align_reg == '0) ? ALIGN_W'(1) : align_reg;

    // Allocate: fit test and the two possible remaining fragments.
    assign need33    = {1'b0, len_in_reg} + (WORD_W+1)'(off_reg);
    assign a_fit     = ({1'b0, cur_reg.size} >= need33);
    assign addr33    = {1'b0, cur_reg.start} + (WORD_W+1)'(off_reg);
    assign end34     = (WORD_W+2)'(cur_reg.start) + (WORD_W+2)'(cur_reg.size);
    assign sum34     = (WORD_W+2)'(addr33) + (WORD_W+2)'(len_in_reg);
    assign tail34    = (sum34 + (WORD_W+2)'(GRANULE - 1)) & ~((WORD_W+2)'(GRANULE - 1));
    assign tsz34     = end34 - tail34;
    assign keep_lead = (off_reg >= ALIGN_W'(HEADER_BYTES));
    assign keep_tail = (end34 >= tail34) && (tsz34 >= (WORD_W+2)'(HEADER_BYTES));
    assign tbl_full  = (count_reg >= CNT_W'(MAX_EXTENTS));
    assign a_last    = (idx_inc == count_reg);
    assign lead_ext  = '{start: cur_reg.start, size: WORD_W'(off_reg) & GMASK};
    assign tail_ext  = '{start: tail34[WORD_W-1:0], size: tsz34[WORD_W-1:0]};

    // Deallocate: neighbour tests against the extents below and at the address.
    assign f_below   = (mem_rdata.start < ra_reg);
    assign f_last    = (idx_inc == count_reg);
    assign cur_ok    = (idx_reg < count_reg);
    assign prev_end  = {1'b0, prev_reg.start} + {1'b0, prev_reg.size};
    assign merge_lo  = have_prev_reg && (prev_end == {1'b0, ra_reg});
    assign psize1    = sat_add(prev_reg.size, rs_reg);
    assign prev_end2 = {1'b0, prev_reg.start} + {1'b0, psize1};
    assign merge_hi  = cur_ok && (prev_end2 == {1'b0, cur_reg.start});
    assign psize2    = sat_add(psize1, cur_reg.size);
    assign rel_end   = {1'b0, ra_reg} + {1'b0, rs_reg};
    assign merge_up  = cur_ok && (rel_end == {1'b0, cur_reg.start});
    assign up_size   = sat_add(rs_reg, cur_reg.size);

    ffha_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffha_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mem_rdata.start),
        .divisor  (align_eff),
        .res      (mod_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_act)
                        ACT_ALLOC: state_next = (count_reg == '0) ? S_STAT : S_A_RD;
                        ACT_FREE:
                        begin
                            if (rs_in == '0)
                                state_next = S_STAT;
                            else if (count_reg == '0)
                                state_next = S_F_DECIDE;
                            else
                                state_next = S_F_RD;
                        end
                        default:   state_next = S_STAT;
                    endcase
                end
            end
            S_A_RD:   state_next = S_A_WAIT;
            S_A_WAIT: state_next = S_A_MOD;
            S_A_MOD:  state_next = mod_res.done ? S_A_EVAL : S_A_MOD;
            S_A_EVAL:
            begin
                if (!a_fit)
                    state_next = a_last ? S_STAT : S_A_RD;
                else if (keep_lead && keep_tail)
                    state_next = tbl_full ? S_STAT : S_INS;
                else if (keep_lead || keep_tail)
                    state_next = S_STAT;
                else
                    state_next = S_DEL;
            end
            S_F_RD:   state_next = S_F_WAIT;
            S_F_WAIT:
            begin
                if (f_below && !f_last)
                    state_next = S_F_RD;
                else
                    state_next = S_F_DECIDE;
            end
            S_F_DECIDE:
            begin
                if (merge_lo)
                    state_next = merge_hi ? S_DEL : S_STAT;
                else if (merge_up || tbl_full)
                    state_next = S_STAT;
                else
                    state_next = S_INS;
            end
            S_INS:     state_next = (pos_reg == count_reg) ? S_INS_PUT : S_INS_RD;
            S_INS_RD:  state_next = S_INS_WR;
            S_INS_WR:  state_next = (idx_reg == pos_reg) ? S_INS_PUT : S_INS_RD;
            S_INS_PUT: state_next = S_STAT;
            S_DEL:     state_next = (CNT_W'(pos_reg + 1'b1) == count_reg) ? S_STAT : S_DEL_RD;
            S_DEL_RD:  state_next = S_DEL_WR;
            S_DEL_WR:
                state_next = (CNT_W'(idx_reg + 2'd2) == count_reg) ? S_STAT : S_DEL_RD;
            S_STAT:    state_next = (count_reg == '0) ? S_DONE : S_ST_RD;
            S_ST_RD:   state_next = S_ST_ACC;
            S_ST_ACC:  state_next = (idx_inc == count_reg) ? S_DONE : S_ST_RD;
            S_DONE:    state_next = (!m_tvalid_reg || m_tready) ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Table port and remainder unit controls.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[EXT_AW-1:0];
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = idx_reg[EXT_AW-1:0];
        mod_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_act == ACT_INIT && init_usable != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = '{start: init_base & GMASK, size: init_usable};
                end
            end
            S_A_RD, S_F_RD, S_INS_RD, S_ST_RD:
            begin
                mem_re = 1'b1;
            end
            S_DEL_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_inc[EXT_AW-1:0];
            end
            S_A_WAIT:
            begin
                mod_start = 1'b1;
            end
            S_A_EVAL:
            begin
                if (a_fit && !(keep_lead && keep_tail && tbl_full))
                begin
                    if (keep_lead)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = lead_ext;
                    end
                    else if (keep_tail)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = tail_ext;
                    end
                end
            end
            S_F_DECIDE:
            begin
                if (merge_lo)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_dec[EXT_AW-1:0];
                    mem_wdata = '{start: prev_reg.start, size: merge_hi ? psize2 : psize1};
                end
                else if (merge_up)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{start: ra_reg, size: up_size};
                end
            end
            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_inc[EXT_AW-1:0];
            end
            S_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[EXT_AW-1:0];
                mem_wdata = ins_reg;
            end
            S_DEL_WR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        count_next     = count_reg;
        usable_next    = usable_reg;
        len_in_next    = len_in_reg;
        align_next     = align_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        ins_next       = ins_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        off_next       = off_reg;
        ra_next        = ra_reg;
        rs_next        = rs_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        total_next     = total_reg;
        largest_next   = largest_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    len_in_next    = in_len;
                    align_next     = in_align;
                    ra_next        = in_addr & GMASK;
                    rs_next        = rs_in;
                    idx_next       = '0;
                    have_prev_next = 1'b0;
                    status_next    = ST_OK;
                    granted_next   = '0;
                    if (in_act == ACT_INIT)
                    begin
                        usable_next = init_usable;
                        count_next  = (init_usable != '0) ? CNT_W'(1) : '0;
                    end
                    else if (in_act == ACT_ALLOC && count_reg == '0)
                    begin
                        status_next = ST_NO_MEMORY;
                    end
                end
            end
            S_A_WAIT:
            begin
                cur_next = mem_rdata;
            end
            S_A_MOD:
            begin
                if (mod_res.done)
                begin
                    off_next = (mod_res.rem == '0) ? '0 : ALIGN_W'(align_eff - mod_res.rem);
                end
            end
            S_A_EVAL:
            begin
                if (!a_fit)
                begin
                    idx_next = idx_inc;
                    if (a_last)
                        status_next = ST_NO_MEMORY;
                end
                else if (keep_lead && keep_tail && tbl_full)
                begin
                    status_next = ST_TABLE_FULL;
                end
                else
                begin
                    granted_next = addr33[WORD_W-1:0];
                    pos_next     = keep_lead ? idx_inc : idx_reg;
                    ins_next     = tail_ext;
                end
            end
            S_F_WAIT:
            begin
                cur_next = mem_rdata;
                if (f_below)
                begin
                    prev_next      = mem_rdata;
                    have_prev_next = 1'b1;
                    idx_next       = idx_inc;
                end
            end
            S_F_DECIDE:
            begin
                pos_next = idx_reg;
                ins_next = '{start: ra_reg, size: rs_reg};
                if (!merge_lo && !merge_up && tbl_full)
                    status_next = ST_TABLE_FULL;
            end
            S_INS:
            begin
                idx_next = count_reg - 1'b1;
            end
            S_INS_WR:
            begin
                idx_next = idx_dec;
            end
            S_INS_PUT:
            begin
                count_next = count_reg + 1'b1;
            end
            S_DEL:
            begin
                idx_next = pos_reg;
                if (CNT_W'(pos_reg + 1'b1) == count_reg)
                    count_next = count_reg - 1'b1;
            end
            S_DEL_WR:
            begin
                idx_next = idx_inc;
                if (CNT_W'(idx_reg + 2'd2) == count_reg)
                    count_next = count_reg - 1'b1;
            end
            S_STAT:
            begin
                idx_next     = '0;
                total_next   = '0;
                largest_next = '0;
            end
            S_ST_ACC:
            begin
                total_next = total_reg + mem_rdata.size;
                if (mem_rdata.size > largest_reg)
                    largest_next = mem_rdata.size;
                idx_next = idx_inc;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0,
                                     usable_reg - total_reg,
                                     largest_reg,
                                     total_reg,
                                     (status_reg == ST_OK) ? granted_reg : '0,
                                     status_reg};
                end
            end
            default:
            begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            usable_reg    <= '0;
            base_cfg_reg  <= '0;
            len_cfg_reg   <= '0;
            have_prev_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            usable_reg    <= usable_next;
            have_prev_reg <= have_prev_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_HEAP_BASE:   base_cfg_reg <= cfg_data;
                    CFG_HEAP_LENGTH: len_cfg_reg  <= cfg_data;
                    default:         base_cfg_reg <= base_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_in_reg  <= len_in_next;
        align_reg   <= align_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        ins_reg     <= ins_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        off_reg     <= off_next;
        ra_reg      <= ra_next;
        rs_reg      <= rs_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        total_reg   <= total_next;
        largest_reg <= largest_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The table never holds more extents than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_EXTENTS))
        else $error("extent count above table depth");

    // In-place updates only touch live rows of the table.
    a_inplace_live: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && (state_reg == S_A_EVAL || state_reg == S_F_DECIDE)
        |-> ({1'b0, mem_waddr} < count_reg))
        else $error("in-place write beyond the live extents");

    // The remainder result only arrives while the allocator waits for it.
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_res.done |-> (state_reg == S_A_MOD))
        else $error("remainder finished outside its wait state");

endmodule

`default_nettype wire

/* design/ffha_mem.sv */
// ----------------------------------------------------------------------------
// ffha_mem
// Extent table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_mem (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [ffha_pkg::EXT_AW-1:0] waddr,
    input  wire ffha_pkg::ext_t            wdata,
    input  wire logic                      re,
    input  wire logic [ffha_pkg::EXT_AW-1:0] raddr,
    output ffha_pkg::ext_t                 rdata
);
    import ffha_pkg::*;

    ext_t mem [MAX_EXTENTS];
    ext_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/ffha_mod.sv */
// ----------------------------------------------------------------------------
// ffha_mod
// Bit-serial remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ffha_pkg::WORD_W-1:0]  dividend,
    input  wire logic [ffha_pkg::ALIGN_W-1:0] divisor,
    output ffha_pkg::mod_res_t               res
);
    import ffha_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ALIGN_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [ALIGN_W-1:0]   div_reg, div_next;
    logic [REM_W-1:0]     trial;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(WORD_W);
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = ALIGN_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[ALIGN_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign res = '{busy: busy_reg, done: done_reg, rem: rem_reg};

endmodule

`default_nettype wire
